// ===== hw/rtl/escaped_text_to_utf16_parser_unit_macros.svh =====
// Assertion macros for the escaped text to UTF-16 parser.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ESCAPED_TEXT_TO_UTF16_PARSER_UNIT_MACROS_SVH
`define ESCAPED_TEXT_TO_UTF16_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETU16P_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ETU16P_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/etu16p_pkg.sv =====
// Package for the escaped text to UTF-16 parser: phase and status codes,
// character constants, state and result structs, and the hex digit decoder.
// No dependencies.
package etu16p_pkg;

	typedef enum logic [2:0] {
		PH_PLAIN  = 3'd0,
		PH_ESCAPE = 3'd1,
		PH_HEX1   = 3'd2,
		PH_HEX2   = 3'd3,
		PH_HEX3   = 3'd4,
		PH_HEX4   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_BYTE   = 3'd1,
		ST_BAD_ESCAPE = 3'd2,
		ST_TRUNCATED  = 3'd3,
		ST_BAD_HEX    = 3'd4
	} status_t;

	localparam logic [7:0] CH_SPACE_MIN = 8'h20;
	localparam logic [7:0] CH_HIGH_MIN  = 8'h80;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_LOW_B     = 8'h62;
	localparam logic [7:0] CH_LOW_F     = 8'h66;
	localparam logic [7:0] CH_LOW_N     = 8'h6E;
	localparam logic [7:0] CH_LOW_R     = 8'h72;
	localparam logic [7:0] CH_LOW_T     = 8'h74;
	localparam logic [7:0] CH_LOW_U     = 8'h75;

	localparam logic [15:0] CU_BS = 16'h0008;
	localparam logic [15:0] CU_FF = 16'h000C;
	localparam logic [15:0] CU_LF = 16'h000A;
	localparam logic [15:0] CU_CR = 16'h000D;
	localparam logic [15:0] CU_HT = 16'h0009;

	typedef struct packed {
		phase_t      phase;
		logic [11:0] hex_acc;
		status_t     err;
	} state_t;

	typedef struct packed {
		logic        emit;
		logic        unit_valid;
		logic [15:0] char_unit;
		logic        message_end;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t d;
		d = '{ok: 1'b0, value: 4'd0};
		if (b inside {[8'h30:8'h39]}) begin
			d = '{ok: 1'b1, value: 4'(b - 8'h30)};
		end else if (b inside {[8'h61:8'h66]}) begin
			d = '{ok: 1'b1, value: 4'(b - 8'h57)};
		end else if (b inside {[8'h41:8'h46]}) begin
			d = '{ok: 1'b1, value: 4'(b - 8'h37)};
		end
		return d;
	endfunction

endpackage

// ===== hw/rtl/etu16p_step.sv =====
// Per-byte decode step: next parser state and the result for one item.
// Purely combinational; depends on etu16p_pkg.
module etu16p_step (
	input  logic [7:0]          text_byte,
	input  logic                final_byte,
	input  etu16p_pkg::state_t  cur,
	output etu16p_pkg::state_t  nxt,
	output etu16p_pkg::result_t res
);
	import etu16p_pkg::*;

	state_t      s;
	logic        have_unit;
	logic [15:0] unit;
	hex_digit_t  d;

	always_comb begin
		s         = cur;
		have_unit = 1'b0;
		unit      = 16'h0000;
		d         = hex_decode(text_byte);
		if (cur.err == ST_OK) begin
			case (cur.phase)
				PH_PLAIN: begin
					if ((text_byte < CH_SPACE_MIN || text_byte >= CH_HIGH_MIN)
							&& text_byte != CH_LF) begin
						s.err = ST_BAD_BYTE;
					end else if (text_byte == CH_BSLASH) begin
						s.phase = PH_ESCAPE;
					end else begin
						have_unit = 1'b1;
						unit      = {8'h00, text_byte};
					end
				end
				PH_ESCAPE: begin
					s.phase   = PH_PLAIN;
					have_unit = 1'b1;
					case (text_byte)
						CH_QUOTE:  unit = {8'h00, CH_QUOTE};
						CH_BSLASH: unit = {8'h00, CH_BSLASH};
						CH_SLASH:  unit = {8'h00, CH_SLASH};
						CH_LOW_B:  unit = CU_BS;
						CH_LOW_F:  unit = CU_FF;
						CH_LOW_N:  unit = CU_LF;
						CH_LOW_R:  unit = CU_CR;
						CH_LOW_T:  unit = CU_HT;
						CH_LOW_U: begin
							have_unit = 1'b0;
							s.phase   = PH_HEX1;
							s.hex_acc = 12'h000;
						end
						default: begin
							have_unit = 1'b0;
							s.err     = ST_BAD_ESCAPE;
						end
					endcase
				end
				PH_HEX1, PH_HEX2, PH_HEX3: begin
					if (!d.ok) begin
						s.err = ST_BAD_HEX;
					end else begin
						s.hex_acc = {cur.hex_acc[7:0], d.value};
						s.phase   = phase_t'(cur.phase + 3'd1);
					end
				end
				PH_HEX4: begin
					if (!d.ok) begin
						s.err = ST_BAD_HEX;
					end else begin
						have_unit = 1'b1;
						unit      = {cur.hex_acc, d.value};
						s.hex_acc = 12'h000;
						s.phase   = PH_PLAIN;
					end
				end
				default: begin
					s.err = ST_BAD_ESCAPE;
				end
			endcase
		end
		if (final_byte && s.err == ST_OK && s.phase != PH_PLAIN) begin
			s.err = ST_TRUNCATED;
		end

		res.emit        = have_unit || final_byte;
		res.unit_valid  = have_unit && s.err == ST_OK;
		res.char_unit   = (have_unit && s.err == ST_OK) ? unit : 16'h0000;
		res.message_end = final_byte;
		res.status      = final_byte ? s.err : ST_OK;

		if (final_byte) begin
			nxt = '{phase: PH_PLAIN, hex_acc: 12'h000, err: ST_OK};
		end else begin
			nxt = s;
		end
	end

endmodule

// ===== hw/rtl/escaped_text_to_utf16_parser_unit.sv =====
// Top level of the escaped text to UTF-16 parser: input register, parser state and
// result register around the decode step. Depends on etu16p_pkg, etu16p_step and the macro header.
//
// The unit takes one byte of escaped text per cycle and returns a UTF-16 code unit for every
// plain character or completed escape, plus one result carrying the message status for the
// last byte. Each byte passes through an input register and a result register before its
// result is presented. The sustained rate is one byte per cycle; it drops only while the
// result register holds an item that the consumer stalls and the byte in the input register
// has a result to deliver. Bytes that produce no result never wait for the output. After
// an error the rest of the message is consumed silently and the status arrives with the
// last byte.
`include "escaped_text_to_utf16_parser_unit_macros.svh"

module escaped_text_to_utf16_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        unit_valid,
	output logic [15:0] char_unit,
	output logic        message_end,
	output logic [2:0]  status
);
	import etu16p_pkg::*;

	logic        valid_s1;
	logic [7:0]  text_byte_s1;
	logic        final_byte_s1;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res;
	logic        out_free;
	logic        adv_s1;
	logic        out_valid_s2;
	logic        unit_valid_s2;
	logic [15:0] char_unit_s2;
	logic        message_end_s2;
	status_t     status_s2;

	etu16p_step u_step (
		.text_byte  (text_byte_s1),
		.final_byte (final_byte_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	assign out_free = !out_valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && (!res.emit || out_free);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			text_byte_s1  <= text_byte;
			final_byte_s1 <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_PLAIN, hex_acc: 12'h000, err: ST_OK};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= adv_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && res.emit) begin
			unit_valid_s2  <= res.unit_valid;
			char_unit_s2   <= res.char_unit;
			message_end_s2 <= res.message_end;
			status_s2      <= res.status;
		end
	end

	assign out_valid   = out_valid_s2;
	assign unit_valid  = unit_valid_s2;
	assign char_unit   = char_unit_s2;
	assign message_end = message_end_s2;
	assign status      = 3'(status_s2);

	`ETU16P_ASSERT_IMP(a_unit_means_ok, clk, arst_n, out_valid_s2 && unit_valid_s2, status_s2 == ST_OK, "A decoded item carries an error status.")
	`ETU16P_ASSERT_IMP(a_status_only_at_end, clk, arst_n, out_valid_s2 && !message_end_s2, status_s2 == ST_OK, "A status is reported before the end of the message.")
	`ETU16P_ASSERT_NXT(a_state_clears_at_end, clk, arst_n, adv_s1 && final_byte_s1, state_q.phase == PH_PLAIN && state_q.err == ST_OK && state_q.hex_acc == 12'h000, "Parser state not cleared after the last byte.")
	`ETU16P_ASSERT_IMP(a_stall_needs_result, clk, arst_n, in_stall, valid_s1 && res.emit && out_valid_s2 && out_stall, "Input stalled without a blocked result.")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for escaped_text_to_utf16_parser_unit: predicts the decoded code units
// and message status of every accepted byte and checks each result as it leaves the unit.
// Depends on etu16p_pkg and the unit's RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import etu16p_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TOTAL_BYTES = 750;
	localparam int TAIL_BYTES = 120;
	localparam logic [63:0] ESCAPE_KINDS = {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
		CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};

	typedef enum int {FLAW_NONE, FLAW_BYTE, FLAW_ESCAPE, FLAW_HEX, FLAW_TRUNC} flaw_t;
	typedef enum int {TOK_PLAIN, TOK_SIMPLE_ESC, TOK_HEX_ESC} token_t;

	typedef struct packed {
		logic [7:0] text;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic        unit_valid;
		logic [15:0] char_unit;
		logic        message_end;
		logic [2:0]  status;
	} unit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        unit_valid;
	logic [15:0] char_unit;
	logic        message_end;
	logic [2:0]  status;

	text_item_t   pending_bytes[$];
	unit_result_t expected_units[$];
	text_item_t   next_item;
	unit_result_t seen_unit;
	unit_result_t wanted_unit;

	phase_t      esc_phase = PH_PLAIN;
	logic [11:0] hex_digits = 12'h000;
	status_t     first_error = ST_OK;

	int bytes_accepted = 0;
	int tail_start = 0;
	int in_gap = 0;
	int out_gap = 0;
	int quiet_cycles = 0;
	int mismatch_count = 0;

	escaped_text_to_utf16_parser_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.unit_valid(unit_valid),
		.char_unit(char_unit),
		.message_end(message_end),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic         have;
		logic         is_hex;
		logic [15:0]  unit;
		logic [3:0]   nib;
		unit_result_t r;
		have = 1'b0;
		unit = 16'h0000;
		if (first_error == ST_OK) begin
			case (esc_phase)
				PH_PLAIN: begin
					if ((b < CH_SPACE_MIN || b >= CH_HIGH_MIN) && b != CH_LF) begin
						first_error = ST_BAD_BYTE;
					end else if (b == CH_BSLASH) begin
						esc_phase = PH_ESCAPE;
					end else begin
						have = 1'b1;
						unit = {8'h00, b};
					end
				end
				PH_ESCAPE: begin
					esc_phase = PH_PLAIN;
					have = 1'b1;
					case (b)
						CH_QUOTE:  unit = {8'h00, CH_QUOTE};
						CH_BSLASH: unit = {8'h00, CH_BSLASH};
						CH_SLASH:  unit = {8'h00, CH_SLASH};
						CH_LOW_B:  unit = CU_BS;
						CH_LOW_F:  unit = CU_FF;
						CH_LOW_N:  unit = CU_LF;
						CH_LOW_R:  unit = CU_CR;
						CH_LOW_T:  unit = CU_HT;
						CH_LOW_U: begin
							have = 1'b0;
							esc_phase = PH_HEX1;
							hex_digits = 12'h000;
						end
						default: begin
							have = 1'b0;
							first_error = ST_BAD_ESCAPE;
						end
					endcase
				end
				default: begin
					is_hex = 1'b1;
					if (b >= 8'h30 && b <= 8'h39) begin
						nib = b[3:0];
					end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
						nib = b[3:0] + 4'd9;
					end else begin
						nib = 4'd0;
						is_hex = 1'b0;
					end
					if (!is_hex) begin
						first_error = ST_BAD_HEX;
					end else if (esc_phase == PH_HEX4) begin
						have = 1'b1;
						unit = {hex_digits, nib};
						hex_digits = 12'h000;
						esc_phase = PH_PLAIN;
					end else begin
						hex_digits = {hex_digits[7:0], nib};
						esc_phase = phase_t'(esc_phase + 3'd1);
					end
				end
			endcase
		end
		if (last && first_error == ST_OK && esc_phase != PH_PLAIN) begin
			first_error = ST_TRUNCATED;
		end
		if (have || last) begin
			r.unit_valid = have && first_error == ST_OK;
			r.char_unit = r.unit_valid ? unit : 16'h0000;
			r.message_end = last;
			r.status = last ? first_error : ST_OK;
			expected_units.insert(expected_units.size(), r);
		end
		if (last) begin
			esc_phase = PH_PLAIN;
			hex_digits = 12'h000;
			first_error = ST_OK;
		end
	endtask

	task automatic log_mismatch(input string what, input unit_result_t want,
		input unit_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected unit_valid=%0b char_unit=%h message_end=%0b status=%0d, got unit_valid=%0b char_unit=%h message_end=%0b status=%0d",
				$time, what, want.unit_valid, want.char_unit, want.message_end, want.status,
				got.unit_valid, got.char_unit, got.message_end, got.status);
		end
	endtask

	function automatic bit gaps_enabled();
		return bytes_accepted < tail_start && (bytes_accepted / 64) % 4 != 3;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + nib;
		end
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_item_t it;
		it.text = b;
		it.last = 1'b0;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	task automatic end_message();
		text_item_t it;
		it = pending_bytes.pop_back();
		it.last = 1'b1;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
		end_message();
	endtask

	task automatic queue_random_message();
		int         n_tokens;
		int         flaw_at;
		int         k;
		flaw_t      flaw;
		token_t     tok;
		logic [7:0] b;
		bit         broken;
		bit         cut;
		n_tokens = $urandom_range(1, 10);
		flaw = ($urandom_range(0, 4) == 0) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
		flaw_at = $urandom_range(0, n_tokens - 1);
		broken = 1'b0;
		cut = 1'b0;
		for (int i = 0; i < n_tokens && !cut; i++) begin
			if (broken) begin
				add_byte(8'($urandom_range(0, 255)));
			end else if (flaw != FLAW_NONE && i == flaw_at) begin
				case (flaw)
					FLAW_BYTE: begin
						if ($urandom_range(0, 1)) begin
							b = 8'($urandom_range(128, 255));
						end else begin
							do b = 8'($urandom_range(0, 31)); while (b == CH_LF);
						end
						add_byte(b);
						broken = 1'b1;
					end
					FLAW_ESCAPE: begin
						do b = 8'($urandom_range(0, 255));
						while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F,
							CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_U});
						add_byte(CH_BSLASH);
						add_byte(b);
						broken = 1'b1;
					end
					FLAW_HEX: begin
						add_byte(CH_BSLASH);
						add_byte(CH_LOW_U);
						k = $urandom_range(0, 3);
						repeat (k) add_byte(hex_char(4'($urandom_range(0, 15))));
						do b = 8'($urandom_range(0, 255));
						while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
						add_byte(b);
						broken = 1'b1;
					end
					default: begin
						add_byte(CH_BSLASH);
						if ($urandom_range(0, 1)) begin
							add_byte(CH_LOW_U);
							k = $urandom_range(0, 3);
							repeat (k) add_byte(hex_char(4'($urandom_range(0, 15))));
						end
						cut = 1'b1;
					end
				endcase
			end else begin
				k = $urandom_range(0, 5);
				tok = (k < 3) ? TOK_PLAIN : (k < 5) ? TOK_SIMPLE_ESC : TOK_HEX_ESC;
				case (tok)
					TOK_PLAIN: begin
						if ($urandom_range(0, 9) == 0) begin
							b = CH_LF;
						end else begin
							do b = 8'($urandom_range(32, 127)); while (b == CH_BSLASH);
						end
						add_byte(b);
					end
					TOK_SIMPLE_ESC: begin
						add_byte(CH_BSLASH);
						add_byte(ESCAPE_KINDS[8 * $urandom_range(0, 7) +: 8]);
					end
					default: begin
						add_byte(CH_BSLASH);
						add_byte(CH_LOW_U);
						repeat (4) add_byte(hex_char(4'($urandom_range(0, 15))));
					end
				endcase
			end
		end
		end_message();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(text_byte, final_byte);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (gaps_enabled() && $urandom_range(0, 5) == 0) begin
					in_gap <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					next_item = pending_bytes.pop_front();
					in_valid <= 1'b1;
					text_byte <= next_item.text;
					final_byte <= next_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_unit = '{unit_valid, char_unit, message_end, status};
				if (expected_units.size() == 0) begin
					log_mismatch("result with no item expected", '0, seen_unit);
				end else begin
					wanted_unit = expected_units.pop_front();
					if (seen_unit.unit_valid !== wanted_unit.unit_valid
						|| seen_unit.char_unit !== wanted_unit.char_unit
						|| seen_unit.message_end !== wanted_unit.message_end
						|| seen_unit.status !== wanted_unit.status) begin
						log_mismatch("result mismatch", wanted_unit, seen_unit);
					end
				end
			end
			if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (gaps_enabled() && $urandom_range(0, 5) == 0) begin
				out_gap <= $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL escaped_text_to_utf16_parser_unit");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		queue_text(" \177\n");
		queue_text("\037");
		queue_text("\377A");
		queue_text("\\n\\uFf09");
		queue_text("\\q");
		queue_text("\\u1g");
		queue_text("\\");
		queue_text("\\u0");
		while (pending_bytes.size() < TOTAL_BYTES) begin
			queue_random_message();
		end
		tail_start = pending_bytes.size() - TAIL_BYTES;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_units.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_units.size() == 0) begin
			$display("PASS escaped_text_to_utf16_parser_unit");
		end else begin
			$display("FAIL escaped_text_to_utf16_parser_unit");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/etu16p_pkg.sv
hw/rtl/etu16p_step.sv
hw/rtl/escaped_text_to_utf16_parser_unit.sv
dv/tb_top.sv
